>>> rtl/lbp_pkg.sv
// shared types, constants and the pattern function of the local binary pattern block
package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int OCOL_W     = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;
    localparam int WIN_COLS   = 3;

    localparam int FRAME_W_RST = 640;
    localparam int FRAME_H_RST = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one window column: pixels of the upper, middle and lower row
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    typedef struct packed {
        logic en;
        logic load;
    } t_cell_ctl;

    // bit 7 top-left, clockwise, bit 0 left
    function automatic logic [PIX_W-1:0] lbp_code(input t_col l, input t_col c, input t_col r);
        logic [PIX_W-1:0] ctr;
        ctr = c.mid;
        return {l.top >= ctr, c.top >= ctr, r.top >= ctr, r.mid >= ctr,
                r.bot >= ctr, c.bot >= ctr, l.bot >= ctr, l.mid >= ctr};
    endfunction

endpackage

>>> rtl/lbp_code_image_core.sv
// 3x3 local binary pattern stream: two line memories, a chain of three window cells
// an accepted item is registered in the window stage, and its result then in the output register
// one item per cycle unless the output stalls, as each line memory has a single read and write port
// a single-row frame takes one extra internal step after its last pixel to prime the drain window
// codes lag the pixels by one row plus one pixel; flush items drain the last row
// reset clears counters and frame state and sets 640x480; line memories are not cleared
module lbp_code_image_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [lbp_pkg::PIX_W-1:0]         i_pixel_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [lbp_pkg::PIX_W-1:0]         o_pattern_code,
    output logic [lbp_pkg::ROW_W-1:0]         o_out_row,
    output logic [lbp_pkg::OCOL_W-1:0]        o_out_col,
    output logic                              o_frame_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int VW = AW + 1;
    localparam int CW = (AW + 1 > lbp_pkg::FW_W) ? AW + 1 : lbp_pkg::FW_W;
    localparam int WL_RST = (lbp_pkg::FRAME_W_RST > MAX_WIDTH) ? MAX_WIDTH - 1
                                                               : lbp_pkg::FRAME_W_RST - 1;
    localparam int RW = lbp_pkg::ROW_W;

    // frame geometry, held as last index
    logic [AW-1:0] r_wlast;
    logic [RW-1:0] r_hlast;

    // issue-side sequencing
    logic [AW-1:0] r_ic, n_ic;
    logic [RW-1:0] r_ir, n_ir;
    logic          r_drain, n_drain;
    logic [VW-1:0] r_vc, n_vc;

    // decoded step of the item being issued
    logic          s_valid, s_load, s_emit, s_write, s_tsel, s_bot_pix, s_last;
    logic [AW-1:0] s_addr, s_col;
    logic [RW-1:0] s_row;

    // window stage
    logic                      r_a_valid, r_a_load, r_a_emit, r_a_write;
    logic                      r_a_tsel, r_a_bot_pix, r_a_last;
    logic [lbp_pkg::PIX_W-1:0] r_a_pix;
    logic [AW-1:0]             r_a_addr, r_a_col;
    logic [RW-1:0]             r_a_row;

    // output register
    logic                       r_o_valid;
    logic [lbp_pkg::PIX_W-1:0]  r_o_code;
    logic [RW-1:0]              r_o_row;
    logic [lbp_pkg::OCOL_W-1:0] r_o_col;
    logic                       r_o_last;

    logic inject, in_fire, adv_a, a_free, issue, cfg_hit;
    logic [CW-1:0] fw_ext;
    logic [AW-1:0] wlast_cfg;
    logic [VW-1:0] vc_end;

    logic [lbp_pkg::PIX_W-1:0] m_rd, t_rd, code;
    lbp_pkg::t_col             col_new;
    lbp_pkg::t_col             w_col [lbp_pkg::WIN_COLS];
    lbp_pkg::t_cell_ctl        cell_ctl;

    // a single-row frame needs its window primed from column 0 before the first flush
    assign inject  = r_drain && (r_vc == '0) && (r_hlast == '0);
    assign adv_a   = r_a_valid && (!r_a_emit || !r_o_valid || i_out_ready);
    assign a_free  = !r_a_valid || adv_a;
    assign o_in_ready = a_free && !inject;
    assign in_fire = i_in_valid && o_in_ready;
    assign issue   = a_free && (in_fire || inject);
    assign o_cfg_ready = 1'b1;
    assign cfg_hit = i_cfg_valid && ((i_cfg_index == lbp_pkg::CFG_FRAME_WIDTH) ||
                                     (i_cfg_index == lbp_pkg::CFG_FRAME_HEIGHT));

    // clamp of the written width to 1..MAX_WIDTH, as last index
    assign fw_ext = CW'(i_cfg_data[lbp_pkg::FW_W-1:0]);
    always_comb begin
        if (fw_ext == '0) begin
            wlast_cfg = '0;
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            wlast_cfg = AW'(MAX_WIDTH - 1);
        end else begin
            wlast_cfg = AW'(fw_ext - CW'(1));
        end
    end

    assign vc_end = VW'(r_wlast) + VW'(1);

    always_comb begin
        n_ic      = r_ic;
        n_ir      = r_ir;
        n_drain   = r_drain;
        n_vc      = r_vc;
        s_valid   = 1'b0;
        s_load    = 1'b0;
        s_emit    = 1'b0;
        s_write   = 1'b0;
        s_tsel    = 1'b0;
        s_bot_pix = 1'b0;
        s_last    = 1'b0;
        s_addr    = r_ic;
        s_col     = r_wlast;
        s_row     = r_ir;
        if (cfg_hit) begin
            n_ic    = '0;
            n_ir    = '0;
            n_drain = 1'b0;
            n_vc    = '0;
        end else if (issue) begin
            if (inject || (i_cmd == lbp_pkg::CMD_FLUSH && r_drain)) begin
                // virtual row below the last one: lower row replicates the middle
                s_valid = 1'b1;
                s_tsel  = (r_hlast == '0);
                s_addr  = r_vc[AW-1:0];
                s_row   = r_hlast;
                if (r_vc == '0) begin
                    s_load = 1'b1;
                    s_emit = (r_hlast != '0);
                    s_row  = r_hlast - RW'(1);
                    s_col  = r_wlast;
                    n_vc   = VW'(1);
                end else if (r_vc == vc_end) begin
                    s_load  = 1'b1;
                    s_emit  = 1'b1;
                    s_col   = r_wlast;
                    s_last  = 1'b1;
                    n_drain = 1'b0;
                    n_vc    = '0;
                end else begin
                    s_emit = 1'b1;
                    s_col  = AW'(r_vc - VW'(1));
                    n_vc   = r_vc + VW'(1);
                end
            end else if (i_cmd == lbp_pkg::CMD_PIXEL) begin
                s_valid   = 1'b1;
                s_write   = 1'b1;
                s_bot_pix = 1'b1;
                s_tsel    = (r_ir == RW'(1));
                s_addr    = r_ic;
                n_drain   = 1'b0;
                n_vc      = '0;
                if (r_ic == '0) begin
                    s_load = 1'b1;
                    s_emit = (r_ir > RW'(1));
                    s_row  = r_ir - RW'(2);
                    s_col  = r_wlast;
                end else begin
                    s_emit = (r_ir != '0);
                    s_row  = r_ir - RW'(1);
                    s_col  = r_ic - AW'(1);
                end
                if (r_ic == r_wlast) begin
                    n_ic = '0;
                    if (r_ir == r_hlast) begin
                        n_ir    = '0;
                        n_drain = 1'b1;
                    end else begin
                        n_ir = r_ir + RW'(1);
                    end
                end else begin
                    n_ic = r_ic + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast   <= AW'(WL_RST);
            r_hlast   <= RW'(lbp_pkg::FRAME_H_RST - 1);
            r_ic      <= '0;
            r_ir      <= '0;
            r_drain   <= 1'b0;
            r_vc      <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == lbp_pkg::CFG_FRAME_WIDTH)) begin
                r_wlast <= wlast_cfg;
            end
            if (i_cfg_valid && (i_cfg_index == lbp_pkg::CFG_FRAME_HEIGHT)) begin
                r_hlast <= (i_cfg_data == '0) ? '0 : i_cfg_data - RW'(1);
            end
            r_ic    <= n_ic;
            r_ir    <= n_ir;
            r_drain <= n_drain;
            r_vc    <= n_vc;
            if (issue) begin
                r_a_valid <= s_valid;
            end else if (adv_a) begin
                r_a_valid <= 1'b0;
            end
            if (adv_a && r_a_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_load    <= s_load;
            r_a_emit    <= s_emit;
            r_a_write   <= s_write;
            r_a_tsel    <= s_tsel;
            r_a_bot_pix <= s_bot_pix;
            r_a_last    <= s_last;
            r_a_pix     <= i_pixel_value;
            r_a_addr    <= s_addr;
            r_a_col     <= s_col;
            r_a_row     <= s_row;
        end
        if (adv_a && r_a_emit) begin
            r_o_code <= code;
            r_o_row  <= r_a_row;
            r_o_col  <= lbp_pkg::OCOL_W'(r_a_col);
            r_o_last <= r_a_last;
        end
    end

    lbp_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (lbp_pkg::PIX_W)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (adv_a && r_a_write),
        .i_waddr (r_a_addr),
        .i_wdata (m_rd),
        .i_re    (issue),
        .i_raddr (s_addr),
        .o_rdata (t_rd)
    );

    lbp_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (lbp_pkg::PIX_W)
    ) u_middle_ram (
        .i_clk   (i_clk),
        .i_we    (adv_a && r_a_write),
        .i_waddr (r_a_addr),
        .i_wdata (r_a_pix),
        .i_re    (issue),
        .i_raddr (s_addr),
        .o_rdata (m_rd)
    );

    // upper row repeats the middle one on the second row of a frame and in the drain of a single-row frame
    always_comb begin
        col_new.top = r_a_tsel ? m_rd : t_rd;
        col_new.mid = m_rd;
        col_new.bot = r_a_bot_pix ? r_a_pix : m_rd;
    end

    assign cell_ctl.en   = adv_a;
    assign cell_ctl.load = r_a_load;

    for (genvar k = 0; k < lbp_pkg::WIN_COLS; k++) begin : g_cell
        lbp_pkg::t_col right_col;
        if (k == lbp_pkg::WIN_COLS - 1) begin : g_edge
            assign right_col = col_new;
        end else begin : g_inner
            assign right_col = w_col[k+1];
        end
        lbp_win_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_right    (right_col),
            .i_load_col (col_new),
            .o_col      (w_col[k])
        );
    end

    // a load step closes the previous row with its right edge replicated
    assign code = lbp_pkg::lbp_code(w_col[1], w_col[2], r_a_load ? w_col[2] : col_new);

    assign o_out_valid    = r_o_valid;
    assign o_pattern_code = r_o_code;
    assign o_out_row      = r_o_row;
    assign o_out_col      = r_o_col;
    assign o_frame_last   = r_o_last;

endmodule

>>> rtl/lbp_line_ram.sv
// one-write one-read line memory with registered read data, write-first on a collision
module lbp_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/lbp_win_cell.sv
// one column cell of the 3x3 window chain: loads a fresh column or takes its right neighbor's
module lbp_win_cell (
    input  logic              i_clk,
    input  lbp_pkg::t_cell_ctl i_ctl,
    input  lbp_pkg::t_col     i_right,
    input  lbp_pkg::t_col     i_load_col,
    output lbp_pkg::t_col     o_col
);

    lbp_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_col <= i_ctl.load ? i_load_col : i_right;
        end
    end

    assign o_col = r_col;

endmodule

>>> verif/tb.sv
// testbench for lbp_code_image_core: predicted pattern codes checked against the core
typedef struct packed {
    logic [lbp_pkg::PIX_W-1:0]  code;
    logic [lbp_pkg::ROW_W-1:0]  row;
    logic [lbp_pkg::OCOL_W-1:0] col;
    logic                       last;
} t_code_item;

localparam int LINE_MAX = 1024;

// tracks frame position, line stores and window, and queues the codes the core owes
class pattern_tracker;
    bit [lbp_pkg::FW_W-1:0]  width_reg;
    bit [lbp_pkg::FH_W-1:0]  height_reg;
    bit [lbp_pkg::PIX_W-1:0] upper_row [LINE_MAX];
    bit [lbp_pkg::PIX_W-1:0] middle_row [LINE_MAX];
    bit [lbp_pkg::PIX_W-1:0] cells [9];
    int                      in_col, in_row, emit_col, emit_row;
    bit                      draining;
    t_code_item              codes_due [$];

    function new();
        width_reg  = lbp_pkg::FRAME_W_RST;
        height_reg = lbp_pkg::FRAME_H_RST;
    endfunction

    function int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_MAX) return LINE_MAX;
        return int'(width_reg);
    endfunction

    function int eff_h();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // v[row*3+col], centre at 4; a neighbour at or above the centre sets its bit
    function bit [7:0] pattern_of(input bit [7:0] v [9]);
        bit [7:0] c;
        c = v[4];
        return {v[0] >= c, v[1] >= c, v[2] >= c, v[5] >= c,
                v[8] >= c, v[7] >= c, v[6] >= c, v[3] >= c};
    endfunction

    // window at the right border: centre column repeated on the right
    function void edge_window(output bit [7:0] v [9]);
        for (int r = 0; r < 3; r++) begin
            v[r*3]   = cells[r*3+1];
            v[r*3+1] = cells[r*3+2];
            v[r*3+2] = cells[r*3+2];
        end
    endfunction

    function void step_emit(input int w);
        emit_col++;
        if (emit_col >= w) begin
            emit_col = 0;
            emit_row = (emit_row + 1) % 4096;
        end
    endfunction

    function void push_code(input bit [7:0] code, input int row, input int col, input bit last);
        t_code_item c;
        c.code = code;
        c.row  = row[11:0];
        c.col  = col[9:0];
        c.last = last;
        codes_due.push_back(c);
    endfunction

    function void set_reg(input logic [lbp_pkg::CFG_IDX_W-1:0] idx,
                          input logic [lbp_pkg::CFG_DATA_W-1:0] data);
        if (idx == lbp_pkg::CFG_FRAME_WIDTH) width_reg = data[10:0];
        else if (idx == lbp_pkg::CFG_FRAME_HEIGHT) height_reg = data;
        else return;
        // a write to the width or height register restarts the frame
        in_col   = 0;
        in_row   = 0;
        emit_col = 0;
        emit_row = 0;
        draining = 0;
    endfunction

    // returns 1 when the item owes a code
    function bit take_item(input logic cmd, input logic [7:0] pix);
        int       w, h, ir, ic, er, ec;
        int       cols [3];
        bit [7:0] t, m, lm;
        bit [7:0] v [9];
        bit       made;
        w    = eff_w();
        h    = eff_h();
        made = 0;
        if (cmd == lbp_pkg::CMD_FLUSH) begin
            er = emit_row;
            ec = emit_col;
            if (!draining || er >= h || ec >= w) return 0;
            if (er + 1 != h) begin
                edge_window(v);
            end else begin
                // last row: bottom neighbours replicate the middle line
                cols[0] = (ec == 0) ? 0 : ec - 1;
                cols[1] = ec;
                cols[2] = (ec + 1 >= w) ? w - 1 : ec + 1;
                for (int c = 0; c < 3; c++) begin
                    lm       = middle_row[cols[c]];
                    v[c]     = (h == 1) ? lm : upper_row[cols[c]];
                    v[3 + c] = lm;
                    v[6 + c] = lm;
                end
            end
            push_code(pattern_of(v), er, ec, er + 1 == h && ec + 1 == w);
            if (er + 1 == h && ec + 1 == w) begin
                draining = 0;
                emit_col = 0;
                emit_row = 0;
            end else begin
                step_emit(w);
            end
            return 1;
        end
        ir = in_row;
        ic = in_col;
        if (ir >= h || ic >= w) begin
            ir = 0;
            ic = 0;
        end
        draining = 0;
        if (ir == 0 && ic == 0) begin
            emit_col = 0;
            emit_row = 0;
        end
        m = middle_row[ic];
        t = upper_row[ic];
        upper_row[ic]  = m;
        middle_row[ic] = pix;
        if (ir == 1) t = m;
        if (ic == 0) begin
            if (ir >= 2) begin
                edge_window(v);
                push_code(pattern_of(v), ir - 2, w - 1, 1'b0);
                step_emit(w);
                made = 1;
            end
            for (int r = 0; r < 3; r++) begin
                cells[r]     = t;
                cells[3 + r] = m;
                cells[6 + r] = pix;
            end
        end else begin
            for (int r = 0; r < 3; r++) begin
                cells[r*3]   = cells[r*3+1];
                cells[r*3+1] = cells[r*3+2];
            end
            cells[2] = t;
            cells[5] = m;
            cells[8] = pix;
            if (ir >= 1) begin
                push_code(pattern_of(cells), ir - 1, ic - 1, 1'b0);
                step_emit(w);
                made = 1;
            end
        end
        ic++;
        if (ic >= w) begin
            ic = 0;
            ir++;
            if (ir >= h) begin
                ir       = 0;
                draining = 1;
            end
        end
        in_col = ic;
        in_row = ir;
        return made;
    endfunction

    function string check_code(input t_code_item got);
        t_code_item want;
        string      diff;
        if (codes_due.size() == 0)
            return $sformatf("unexpected code %02h for row %0d col %0d",
                             got.code, got.row, got.col);
        want = codes_due.pop_front();
        diff = "";
        if (got.code !== want.code)
            diff = {diff, $sformatf(" code %02h want %02h", got.code, want.code)};
        if (got.row !== want.row)
            diff = {diff, $sformatf(" row %0d want %0d", got.row, want.row)};
        if (got.col !== want.col)
            diff = {diff, $sformatf(" col %0d want %0d", got.col, want.col)};
        if (got.last !== want.last)
            diff = {diff, $sformatf(" frame_last %b want %b", got.last, want.last)};
        if (diff != "") diff = {$sformatf("row %0d col %0d:", want.row, want.col), diff};
        return diff;
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_FLUSHES  = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam logic [lbp_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 4'hF;
    localparam logic [7:0] SEED_IMG [9] = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd128,
                                            8'd128, 8'd128, 8'd0, 8'd255};

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic                           i_cmd = lbp_pkg::CMD_PIXEL;
    logic [lbp_pkg::PIX_W-1:0]      i_pixel_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [lbp_pkg::PIX_W-1:0]      o_pattern_code;
    logic [lbp_pkg::ROW_W-1:0]      o_out_row;
    logic [lbp_pkg::OCOL_W-1:0]     o_out_col;
    logic                           o_frame_last;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [lbp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [lbp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pattern_tracker tracker = new();

    bit in_idle, out_idle, hold_req;
    int items_sent, stim_count, codes_checked, reg_writes, errors, cycle_count;

    lbp_code_image_core #(.MAX_WIDTH(LINE_MAX)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pattern_code (o_pattern_code),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: timeout after %0d cycles, %0d codes outstanding",
                     cycle_count, tracker.codes_due.size());
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40) $display("tb: mismatch: %s", what);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (out_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_code_item got;
        string      diff;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got.code = o_pattern_code;
            got.row  = o_out_row;
            got.col  = o_out_col;
            got.last = o_frame_last;
            diff = tracker.check_code(got);
            codes_checked++;
            if (diff != "") report_mismatch(diff);
        end else if (i_rst_n && $isunknown(o_out_valid)) begin
            report_mismatch("o_out_valid unknown");
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(input logic cmd, input logic [7:0] pix);
        int gap;
        bit made;
        gap = (in_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        made = tracker.take_item(cmd, pix);
        items_sent++;
        if (cmd == lbp_pkg::CMD_PIXEL || made) stim_count++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbp_pkg::CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (tracker.codes_due.size() != 0) @(negedge i_clk);
        // items that owe no code may still be in the pipe
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // pixels with stray flushes mixed in, then a run of flushes
    task automatic run_frame(input int npix, input int nflush);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(lbp_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
            // values near a common level make ties with the centre frequent
            if ($urandom_range(0, 3) == 0)
                send_item(lbp_pkg::CMD_PIXEL, 8'(base + $urandom_range(0, 2)));
            else send_item(lbp_pkg::CMD_PIXEL, 8'($urandom_range(0, 255)));
        end
        repeat (nflush) send_item(lbp_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int cur_w, cur_h, kind, drain, r;
        in_idle  = 1;
        out_idle = 1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame with extremes and ties; a flush before anything is pending
        write_reg(lbp_pkg::CFG_FRAME_WIDTH, 12'd3);
        write_reg(lbp_pkg::CFG_FRAME_HEIGHT, 12'd3);
        send_item(lbp_pkg::CMD_FLUSH, 8'hFF);
        for (int i = 0; i < 9; i++) send_item(lbp_pkg::CMD_PIXEL, SEED_IMG[i]);
        repeat (5) send_item(lbp_pkg::CMD_FLUSH, 8'h00);

        // zero width clamps to one column; a pixel during the drain starts a new frame
        write_reg(lbp_pkg::CFG_FRAME_WIDTH, 12'd0);
        write_reg(lbp_pkg::CFG_FRAME_HEIGHT, 12'd2);
        send_item(lbp_pkg::CMD_PIXEL, 8'hFF);
        send_item(lbp_pkg::CMD_PIXEL, 8'h00);
        send_item(lbp_pkg::CMD_FLUSH, 8'h5A);
        send_item(lbp_pkg::CMD_PIXEL, 8'h09);
        send_item(lbp_pkg::CMD_PIXEL, 8'h09);
        send_item(lbp_pkg::CMD_FLUSH, 8'hA5);
        send_item(lbp_pkg::CMD_FLUSH, 8'h3C);

        // oversize width clamps to the line size, zero height is one row
        write_reg(lbp_pkg::CFG_FRAME_WIDTH, 12'h7FF);
        write_reg(lbp_pkg::CFG_FRAME_HEIGHT, 12'd0);
        in_idle = 0;
        run_frame(LINE_MAX, 0);
        // output held off while flushes keep coming, so the core backs up
        hold_req = 1;
        repeat (HOLD_FLUSHES) send_item(lbp_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
        in_idle = 1;

        // tallest frame, cut short; a write to no register must not restart it
        write_reg(lbp_pkg::CFG_FRAME_WIDTH, 12'd4);
        write_reg(lbp_pkg::CFG_FRAME_HEIGHT, 12'hFFF);
        run_frame(6, 0);
        write_reg(CFG_NO_REG, 12'hFFF);
        run_frame(6, 0);
        write_reg(lbp_pkg::CFG_FRAME_WIDTH, 12'd1024);
        run_frame(5, 0);
        cur_w = 1024;

        stim_count = 0;
        while (stim_count < RANDOM_ITEMS) begin
            in_idle  = $urandom_range(0, 3) != 0;
            out_idle = $urandom_range(0, 3) != 0;
            if (cur_w > 40 || $urandom_range(0, 9) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 70) cur_w = $urandom_range(1, 6);
                else if (r < 95) cur_w = $urandom_range(7, 16);
                else cur_w = $urandom_range(17, 40);
                write_reg(lbp_pkg::CFG_FRAME_WIDTH, {1'($urandom_range(0, 1)), 11'(cur_w)});
            end
            cur_h = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 5) : $urandom_range(6, 12);
            write_reg(lbp_pkg::CFG_FRAME_HEIGHT, 12'(cur_h));
            drain = cur_w + ((cur_h > 1) ? 1 : 0);
            repeat ($urandom_range(1, 3)) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    // broken frame, restarted by the next register write
                    run_frame($urandom_range(1, cur_w * cur_h - 1), 0);
                    break;
                end
                if (kind == 1) run_frame(cur_w * cur_h, $urandom_range(0, drain - 1));
                else run_frame(cur_w * cur_h, drain + $urandom_range(0, 2));
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.codes_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("tb: %0d items, %0d codes checked, %0d register writes, %0d cycles",
                 items_sent, codes_checked, reg_writes, cycle_count);
        $display("tb: widths 1..1024 with clamping, heights 1..4095, drains, restarts, stalls");
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end
endmodule
